/* rtl/rbd_pkg.sv */
// Shared widths, reset values and register codes for the rounded box distance core.
package rbd_pkg;

    // Coordinate and register widths
    localparam int CW  = 32;          // signed coordinate word
    localparam int HW  = 31;          // unsigned half-extent and radius
    localparam int DW  = 33;          // point minus center
    localparam int QW  = 34;          // |d| minus half-extent, signed
    localparam int MW  = 33;          // max(q, 0), unsigned
    localparam int SQW = 66;          // square and sum of squares
    localparam int RTW = 33;          // root width, one bit per sqrt stage
    localparam int RW  = RTW + 2;     // partial remainder
    localparam int PW  = 33;          // min(max q, 0) minus radius, signed
    localparam int FW  = 35;          // final sum before clamping
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam logic signed [CW-1:0] CENTER_RST = '0;
    localparam logic [HW-1:0]        HALF_RST   = 31'd65536;
    localparam logic [HW-1:0]        RADIUS_RST = '0;

    // Clamp limits of the result word, at final sum width
    localparam logic signed [FW-1:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [FW-1:0] SAT_MIN = -35'sh0_8000_0000;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5,
        CFG_RADIUS   = 3'd6
    } t_cfg_idx;

endpackage

/* rtl/rbd_point_if.sv */
// Channel carrying one sample point word.
interface rbd_point_if;
    logic                            valid;
    logic                            ready;
    logic signed [rbd_pkg::CW-1:0]   point_x;
    logic signed [rbd_pkg::CW-1:0]   point_y;
    logic signed [rbd_pkg::CW-1:0]   point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

/* rtl/rbd_dist_if.sv */
// Channel carrying one signed distance word.
interface rbd_dist_if;
    logic                            valid;
    logic                            ready;
    logic signed [rbd_pkg::CW-1:0]   signed_distance;

    modport source (output valid, output signed_distance, input ready);
    modport sink   (input valid, input signed_distance, output ready);
endinterface

/* rtl/rounded_box_distance_core.sv */
// Rounded box signed distance core: point in, saturated Q16.16 distance out.
// A point word passes the front stages, the square root stages and the output register, in that order.
// Throughput: one word per cycle while the output is not stalled; the 33-stage square root,
// one root bit per stage, sets the depth. A stall at the output holds every stage in place.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module rounded_box_distance_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rbd_pkg::CW-1:0]              i_cfg_data,
    rbd_point_if.sink                           i_pt,
    rbd_dist_if.source                          o_dist
);

    localparam int CW  = rbd_pkg::CW;
    localparam int HW  = rbd_pkg::HW;
    localparam int DW  = rbd_pkg::DW;
    localparam int QW  = rbd_pkg::QW;
    localparam int MW  = rbd_pkg::MW;
    localparam int SQW = rbd_pkg::SQW;
    localparam int RTW = rbd_pkg::RTW;
    localparam int RW  = rbd_pkg::RW;
    localparam int PW  = rbd_pkg::PW;
    localparam int FW  = rbd_pkg::FW;

    // Configuration registers
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [HW-1:0]        r_hx, r_hy, r_hz, r_rad_cfg;

    // Global advance: every stage moves when the output register can take a word
    logic adv;
    logic acc;

    // Stage 1: point minus center
    logic                 r_d_vld;
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    // Stage 2: q = |d| - h
    logic                 r_q_vld;
    logic signed [QW-1:0] r_qx, r_qy, r_qz;
    // Stage 3: squares and the inside term
    logic                 r_sq_vld;
    logic [SQW-1:0]       r_sqx, r_sqy, r_sqz;
    logic signed [PW-1:0] r_pre_sq;
    // Square root pipeline, entry 0 holds the sum of squares
    logic                 r_sv   [0:RTW];
    logic [SQW-1:0]       r_rdc  [0:RTW];
    logic [RW-1:0]        r_rem  [0:RTW];
    logic [RTW-1:0]       r_root [0:RTW];
    logic signed [PW-1:0] r_pre  [0:RTW];
    // Output register
    logic                 r_out_vld;
    logic signed [CW-1:0] r_out_dist;

    assign adv          = !r_out_vld || o_dist.ready;
    assign acc          = i_pt.valid && adv;
    assign i_pt.ready   = adv;
    assign o_dist.valid = r_out_vld;
    assign o_dist.signed_distance = r_out_dist;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= rbd_pkg::CENTER_RST;
            r_cy      <= rbd_pkg::CENTER_RST;
            r_cz      <= rbd_pkg::CENTER_RST;
            r_hx      <= rbd_pkg::HALF_RST;
            r_hy      <= rbd_pkg::HALF_RST;
            r_hz      <= rbd_pkg::HALF_RST;
            r_rad_cfg <= rbd_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            case (rbd_pkg::t_cfg_idx'(i_cfg_idx))
                rbd_pkg::CFG_CENTER_X: r_cx      <= i_cfg_data;
                rbd_pkg::CFG_CENTER_Y: r_cy      <= i_cfg_data;
                rbd_pkg::CFG_CENTER_Z: r_cz      <= i_cfg_data;
                rbd_pkg::CFG_HALF_X:   r_hx      <= i_cfg_data[HW-1:0];
                rbd_pkg::CFG_HALF_Y:   r_hy      <= i_cfg_data[HW-1:0];
                rbd_pkg::CFG_HALF_Z:   r_hz      <= i_cfg_data[HW-1:0];
                rbd_pkg::CFG_RADIUS:   r_rad_cfg <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld  <= 1'b0;
            r_q_vld  <= 1'b0;
            r_sq_vld <= 1'b0;
            r_sv[0]  <= 1'b0;
        end else if (adv) begin
            r_d_vld  <= i_pt.valid;
            r_q_vld  <= r_d_vld;
            r_sq_vld <= r_q_vld;
            r_sv[0]  <= r_sq_vld;
        end
    end

    // Stage 1: offset the point by the center
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx <= DW'(i_pt.point_x) - DW'(r_cx);
            r_dy <= DW'(i_pt.point_y) - DW'(r_cy);
            r_dz <= DW'(i_pt.point_z) - DW'(r_cz);
        end
    end

    // Stage 2: fold each axis and subtract the half-extent
    logic [DW-1:0] n_ax, n_ay, n_az;
    always_comb begin
        n_ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        n_ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
        n_az = r_dz[DW-1] ? DW'(-r_dz) : DW'(r_dz);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qx <= QW'(n_ax) - QW'(r_hx);
            r_qy <= QW'(n_ay) - QW'(r_hy);
            r_qz <= QW'(n_az) - QW'(r_hz);
        end
    end

    // Stage 3: square the outside parts, take the inside term less the radius
    logic [MW-1:0]        n_mx, n_my, n_mz;
    logic signed [QW-1:0] n_qmax;
    always_comb begin
        n_mx   = r_qx[QW-1] ? '0 : r_qx[MW-1:0];
        n_my   = r_qy[QW-1] ? '0 : r_qy[MW-1:0];
        n_mz   = r_qz[QW-1] ? '0 : r_qz[MW-1:0];
        n_qmax = r_qx;
        if (r_qy > n_qmax) begin
            n_qmax = r_qy;
        end
        if (r_qz > n_qmax) begin
            n_qmax = r_qz;
        end
        if (n_qmax > 0) begin
            n_qmax = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx    <= SQW'(n_mx) * SQW'(n_mx);
            r_sqy    <= SQW'(n_my) * SQW'(n_my);
            r_sqz    <= SQW'(n_mz) * SQW'(n_mz);
            r_pre_sq <= PW'(n_qmax) - PW'(r_rad_cfg);
        end
    end

    // Stage 4: sum the squares and seed the square root
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rdc[0]  <= r_sqx + r_sqy + r_sqz;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_pre[0]  <= r_pre_sq;
        end
    end

    // Square root: one root bit per stage, restoring, top digit pair first
    for (genvar s = 1; s <= RTW; s++) begin : g_sqrt
        logic [RW+1:0] n_sh;
        logic [RW+1:0] n_trial;
        logic          n_ge;

        always_comb begin
            n_sh    = {r_rem[s-1], r_rdc[s-1][SQW-1:SQW-2]};
            n_trial = (RW+2)'({r_root[s-1], 2'b01});
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (adv) begin
                r_sv[s] <= r_sv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rdc[s]  <= r_rdc[s-1] << 2;
                r_rem[s]  <= n_ge ? RW'(n_sh - n_trial) : RW'(n_sh);
                r_root[s] <= {r_root[s-1][RTW-2:0], n_ge};
                r_pre[s]  <= r_pre[s-1];
            end
        end
    end

    // Output stage: add root and inside term, clamp to the word range
    logic signed [FW-1:0] n_fsum;
    logic signed [CW-1:0] n_dist;
    always_comb begin
        n_fsum = $signed(FW'(r_root[RTW])) + FW'(r_pre[RTW]);
        if (n_fsum > rbd_pkg::SAT_MAX) begin
            n_dist = CW'(rbd_pkg::SAT_MAX);
        end else if (n_fsum < rbd_pkg::SAT_MIN) begin
            n_dist = CW'(rbd_pkg::SAT_MIN);
        end else begin
            n_dist = n_fsum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_sv[RTW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_dist <= n_dist;
        end
    end

`ifndef SYNTHESIS
    // An accepted point word enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_d_vld)
        else $error("accepted point did not enter stage 1");

    // A stalled output holds the last root stage in place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_sv[RTW]) && $stable(r_root[RTW]) && $stable(r_pre[RTW])))
        else $error("sqrt stage moved during a stall");

    // Root bounds the final remainder from above: floor square root
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[RTW] |-> (r_rem[RTW] <= RW'({r_root[RTW], 1'b0})))
        else $error("square root remainder out of range");

    // A point inside the box on every axis has no outside length
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_q_vld && r_qx <= 0 && r_qy <= 0 && r_qz <= 0)
        |=> (r_sqx == '0 && r_sqy == '0 && r_sqz == '0))
        else $error("inside point produced a nonzero square");

    // Inside term never exceeds zero once the radius is taken off
    a_pre_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> (r_pre_sq <= 0))
        else $error("inside term positive");
`endif

endmodule
